### hw/rtl/sbfb_pkg.sv
// ----------------------------------------------------------------------------
// sbfb_pkg
// Types, codes and helpers shared by the scaled biquad filter bank.
// ----------------------------------------------------------------------------
package sbfb_pkg;

   // Datapath widths
   localparam int DATA_W      = 16;               // Q4.12 samples, Q2.14 coefficients
   localparam int PROD_W      = 2 * DATA_W;       // one 16 x 16 product
   localparam int ACC_W       = PROD_W + 3;       // five products summed, plus headroom
   localparam int SHR_W       = 21;               // width after the rounding shift
   localparam int FEATURE_W   = 3;                // reported feature index
   localparam int SLOT_W      = 3;
   localparam int FUNC_W      = 2;

   // Stream packing
   localparam int REQ_TDATA_W = 40;               // 38 bits of fields, padded to bytes
   localparam int RSP_TDATA_W = 24;               // 19 bits of fields, padded to bytes

   // Defaults
   localparam int                 DEF_FEATURE_COUNT = 8;
   localparam logic signed [15:0] GAIN_RESET        = 16'sd4096;   // 1.0 in Q4.12

   // Request kinds
   typedef enum logic [FUNC_W-1:0] {
      FUNC_FILTER = 2'd0,
      FUNC_WRITE  = 2'd1,
      FUNC_CLEAR  = 2'd2
   } func_type;

   // Coefficient slots within one biquad
   typedef enum logic [SLOT_W-1:0] {
      SLOT_B0 = 3'd0,
      SLOT_B1 = 3'd1,
      SLOT_B2 = 3'd2,
      SLOT_A1 = 3'd3,
      SLOT_A2 = 3'd4
   } slot_type;

   // Control handed to every cell
   typedef struct packed {
      logic                     adv;     // chain advances this cycle
      logic                     clr;     // clear histories
      logic                     wr;      // coefficient write for this cell
      logic [SLOT_W-1:0]        slot;
      logic signed [DATA_W-1:0] value;
   } cell_ctl_type;

   // Result offered by a cell in its summing step
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] response;
   } cell_res_type;

   // Saturate a shifted value to 16 bits signed
   function automatic logic signed [DATA_W-1:0] sat16(input logic signed [SHR_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > 21'sd32767) begin
         r = 16'sd32767;
      end else if (v < -21'sd32768) begin
         r = -16'sd32768;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

### hw/rtl/sbfb_scaler.sv
// ----------------------------------------------------------------------------
// sbfb_scaler
// Multiplies a sample by the input gain, rounds half up and saturates.
// ----------------------------------------------------------------------------
module sbfb_scaler
   import sbfb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     load,
   input  logic signed [DATA_W-1:0] sample,
   input  logic signed [DATA_W-1:0] gain,
   output logic signed [DATA_W-1:0] x_out,
   output logic                     xv_out
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     pv_ff, pv_in;
   logic signed [DATA_W-1:0] x_ff, x_in;
   logic                     xv_ff, xv_in;
   logic signed [PROD_W:0]   rnd;

   // Stage one: the product, taken when a sample request is accepted
   always_comb begin
      prod_in = prod_ff;
      pv_in   = adv ? 1'b0 : pv_ff;
      if (load) begin
         prod_in = sample * gain;
         pv_in   = 1'b1;
      end
   end

   // Stage two: round half up, shift to Q4.12, saturate
   assign rnd = (PROD_W+1)'(prod_ff) + 33'sd2048;

   always_comb begin
      x_in  = x_ff;
      xv_in = xv_ff;
      if (adv) begin
         x_in  = sat16(SHR_W'(rnd >>> 12));
         xv_in = pv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         xv_ff <= 1'b0;
      end else begin
         pv_ff <= pv_in;
         xv_ff <= xv_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      x_ff    <= x_in;
   end

   assign x_out  = x_ff;
   assign xv_out = xv_ff;

endmodule

### hw/rtl/sbfb_cell.sv
// ----------------------------------------------------------------------------
// sbfb_cell
// One direct form I biquad: coefficients, history, products and sum.
// ----------------------------------------------------------------------------
module sbfb_cell
   import sbfb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cell_ctl_type             ctl,
   input  logic signed [DATA_W-1:0] x_in,
   input  logic                     xv_in,
   output logic signed [DATA_W-1:0] x_out,
   output logic                     xv_out,
   output cell_res_type             res
);

   logic signed [DATA_W-1:0] b0_ff, b0_in, b1_ff, b1_in, b2_ff, b2_in;
   logic signed [DATA_W-1:0] a1_ff, a1_in, a2_ff, a2_in;
   logic signed [DATA_W-1:0] x1_ff, x1_in, x2_ff, x2_in;
   logic signed [DATA_W-1:0] y1_ff, y1_in, y2_ff, y2_in;
   logic signed [PROD_W-1:0] p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic signed [PROD_W-1:0] p3_ff, p3_in, p4_ff, p4_in;
   logic                     pv_ff, pv_in;
   logic signed [DATA_W-1:0] x_ff, x_in_d;
   logic                     xv_ff, xv_in_d;
   logic signed [ACC_W-1:0]  acc;
   logic signed [DATA_W-1:0] y;

   // Summing step: Q6.26 sum, round half up, back to Q4.12
   assign acc = ACC_W'(p0_ff) + ACC_W'(p1_ff) + ACC_W'(p2_ff)
              - ACC_W'(p3_ff) - ACC_W'(p4_ff) + 35'sd8192;
   assign y   = sat16(SHR_W'(acc >>> 14));

   // Coefficient writes
   always_comb begin
      b0_in = b0_ff;
      b1_in = b1_ff;
      b2_in = b2_ff;
      a1_in = a1_ff;
      a2_in = a2_ff;
      if (ctl.wr) begin
         case (slot_type'(ctl.slot))
            SLOT_B0: b0_in = ctl.value;
            SLOT_B1: b1_in = ctl.value;
            SLOT_B2: b2_in = ctl.value;
            SLOT_A1: a1_in = ctl.value;
            SLOT_A2: a2_in = ctl.value;
            default: ;
         endcase
      end
   end

   // Product step and history update
   always_comb begin
      x1_in = x1_ff;
      x2_in = x2_ff;
      y1_in = y1_ff;
      y2_in = y2_ff;
      p0_in = p0_ff;
      p1_in = p1_ff;
      p2_in = p2_ff;
      p3_in = p3_ff;
      p4_in = p4_ff;
      if (ctl.clr) begin
         x1_in = '0;
         x2_in = '0;
         y1_in = '0;
         y2_in = '0;
      end
      if (ctl.adv && xv_in) begin
         p0_in = x_in  * b0_ff;
         p1_in = x1_ff * b1_ff;
         p2_in = x2_ff * b2_ff;
         p3_in = y1_ff * a1_ff;
         p4_in = y2_ff * a2_ff;
         x1_in = x_in;
         x2_in = x1_ff;
      end
      if (ctl.adv && pv_ff) begin
         y1_in = y;
         y2_in = y1_ff;
      end
   end

   // Hand the scaled sample on to the neighbour
   always_comb begin
      x_in_d  = ctl.adv ? x_in  : x_ff;
      xv_in_d = ctl.adv ? xv_in : xv_ff;
      pv_in   = ctl.adv ? xv_in : pv_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= '0;
         b1_ff <= '0;
         b2_ff <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
         pv_ff <= 1'b0;
         xv_ff <= 1'b0;
      end else begin
         b0_ff <= b0_in;
         b1_ff <= b1_in;
         b2_ff <= b2_in;
         a1_ff <= a1_in;
         a2_ff <= a2_in;
         x1_ff <= x1_in;
         x2_ff <= x2_in;
         y1_ff <= y1_in;
         y2_ff <= y2_in;
         pv_ff <= pv_in;
         xv_ff <= xv_in_d;
      end
   end

   always_ff @(posedge clock) begin
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      p3_ff <= p3_in;
      p4_ff <= p4_in;
      x_ff  <= x_in_d;
   end

   assign x_out        = x_ff;
   assign xv_out       = xv_ff;
   assign res.valid    = pv_ff;
   assign res.response = y;

endmodule

### hw/rtl/scaled_biquad_filter_bank.sv
// ----------------------------------------------------------------------------
// scaled_biquad_filter_bank
// Gain-scaled sample fed through a row of direct form I biquad cells.
// ----------------------------------------------------------------------------
//  channel  direction  ports                      carries
//  req      in         req_tvalid/tready/tdata    sample, target, slot, value
//                      req_tuser                  func
//  rsp      out        rsp_tvalid/tready/tdata    feature, response
//                      rsp_tlast                  last
//  csr      in         csr_valid/ready/data       input gain
//
//  A sample runs from acceptance through the scaler's product and rounding
//  registers and then along the cell row; the scaled sample walks the row one
//  cell per cycle while the row advances, and each cell has a product step and
//  a summing step. A new sample is not taken until the last one is through.
//  Coefficient writes and clears are registered when accepted. Reset is
//  synchronous and restores unit gain, zero coefficients and zero histories.
//  A stalled response freezes the whole row; requests are taken once the last
//  response is queued.
// ----------------------------------------------------------------------------
module scaled_biquad_filter_bank
   import sbfb_pkg::*;
#(
   parameter int FEATURE_COUNT = DEF_FEATURE_COUNT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // sample, target_feature, coefficient_slot,
                                               // coefficient_value, zero pad
   input  logic [FUNC_W-1:0]      req_tuser,   // func
   // response
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // feature, response, zero pad
   output logic                   rsp_tlast,
   // gain register
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [DATA_W-1:0]      csr_data
);

   logic                     adv;
   logic                     req_acc;
   logic                     do_filter, do_write, do_clear;
   logic signed [DATA_W-1:0] req_sample, req_value;
   logic [FEATURE_W-1:0]     req_target;
   logic [SLOT_W-1:0]        req_slot;

   logic signed [DATA_W-1:0] gain_ff, gain_in;
   logic                     busy_ff, busy_in;

   logic signed [DATA_W-1:0] xc  [FEATURE_COUNT+1];
   logic                     xvc [FEATURE_COUNT+1];
   cell_res_type             res [FEATURE_COUNT];
   logic [FEATURE_COUNT-1:0] res_valid;

   logic                     any_res;
   logic signed [DATA_W-1:0] sel_resp;
   logic [FEATURE_W-1:0]     sel_feat;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_resp_ff, rsp_resp_in;
   logic [FEATURE_W-1:0]     rsp_feat_ff, rsp_feat_in;
   logic                     rsp_last_ff, rsp_last_in;

   // Request fields
   assign req_sample = req_tdata[15:0];
   assign req_target = req_tdata[18:16];
   assign req_slot   = req_tdata[21:19];
   assign req_value  = req_tdata[37:22];

   assign req_tready = !busy_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign adv        = !rsp_valid_ff || rsp_tready;

   // Decode the request kind
   always_comb begin
      do_filter = 1'b0;
      do_write  = 1'b0;
      do_clear  = 1'b0;
      case (func_type'(req_tuser))
         FUNC_FILTER: do_filter = req_acc;
         FUNC_WRITE:  do_write  = req_acc;
         FUNC_CLEAR:  do_clear  = req_acc;
         default: ;
      endcase
   end

   // Gain register
   assign csr_ready = 1'b1;
   assign gain_in   = (csr_valid && csr_ready) ? csr_data : gain_ff;

   // Busy from sample acceptance until its final response is queued
   always_comb begin
      busy_in = busy_ff;
      if (do_filter) begin
         busy_in = 1'b1;
      end else if (adv && res_valid[FEATURE_COUNT-1]) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         busy_ff <= 1'b0;
      end else begin
         gain_ff <= gain_in;
         busy_ff <= busy_in;
      end
   end

   sbfb_scaler u_scaler (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .load   (do_filter),
      .sample (req_sample),
      .gain   (gain_ff),
      .x_out  (xc[0]),
      .xv_out (xvc[0])
   );

   // Row of biquad cells
   for (genvar f = 0; f < FEATURE_COUNT; f++) begin : g_cell
      cell_ctl_type ctl;

      assign ctl.adv   = adv;
      assign ctl.clr   = do_clear;
      assign ctl.wr    = do_write && (int'(req_target) == f);
      assign ctl.slot  = req_slot;
      assign ctl.value = req_value;

      sbfb_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl),
         .x_in   (xc[f]),
         .xv_in  (xvc[f]),
         .x_out  (xc[f+1]),
         .xv_out (xvc[f+1]),
         .res    (res[f])
      );

      assign res_valid[f] = res[f].valid;
   end

   // At most one cell sums in a cycle; pick its result
   always_comb begin
      any_res  = 1'b0;
      sel_resp = '0;
      sel_feat = '0;
      for (int i = 0; i < FEATURE_COUNT; i++) begin
         if (res[i].valid) begin
            any_res  = 1'b1;
            sel_resp = sel_resp | res[i].response;
            sel_feat = sel_feat | FEATURE_W'(i);
         end
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_resp_in  = rsp_resp_ff;
      rsp_feat_in  = rsp_feat_ff;
      rsp_last_in  = rsp_last_ff;
      if (adv) begin
         rsp_valid_in = any_res;
         if (any_res) begin
            rsp_resp_in = sel_resp;
            rsp_feat_in = sel_feat;
            rsp_last_in = res_valid[FEATURE_COUNT-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_resp_ff <= rsp_resp_in;
      rsp_feat_ff <= rsp_feat_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_resp_ff, rsp_feat_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // Only one cell may be in its summing step
   a_one_sum: assert property (@(posedge clock) disable iff (reset)
      $onehot0(res_valid))
      else $error("more than one cell summing");

   // No cell work outside a sample
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (res_valid == '0))
      else $error("cell active while idle");

   // Final response queued ends the sample
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (adv && res_valid[FEATURE_COUNT-1]) |=> (!busy_ff && rsp_tvalid && rsp_tlast))
      else $error("final response did not free the bank");
`endif

endmodule
